// File: rtl/core/fpnc_pkg.sv
// shared types, widths and defaults of the fog palette nearest colour block
package fpnc_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int FOG_LEVELS_DEF      = 128;

    localparam int IDX_W     = 8;
    localparam int CH_W      = 8;
    localparam int LVL_W     = 7;
    localparam int SAT_W     = 8;
    localparam int DIST_W    = 18;
    localparam int RGB_W     = 3 * CH_W;
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 48;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic                       in_range;
        logic [IDX_W-1:0]           index;
        logic [2:0][CH_W-1:0]       rgb;
        logic [LVL_W-1:0]           level_raw;
        logic [SAT_W-1:0]           level_sat;
    } fpnc_item_t;

    typedef struct packed {
        logic [LVL_W-1:0]           level_echo;
        logic [IDX_W-1:0]           source_index;
        logic [DIST_W-1:0]          best_distance;
        logic [IDX_W-1:0]           best_index;
    } fpnc_result_t;

endpackage

// File: rtl/core/fog_palette_nearest_color.sv
// top level of the fog palette nearest colour search
//
//  channel | direction | tdata fields, low bit up                       | tuser
//  s_      | in        | entry_index, red_in, green_in, blue_in,        | action
//          |           | fog_level, zero pad to 40 bits                 |
//  m_      | out       | best_index, best_distance, source_index,       | -
//          |           | level_echo, zero pad to 48 bits                |
//
// a palette write is done as the back end pops it while idle
// a query reads its source entry, blends each colour channel in ST_PROD then
// ST_SCALE and scans; the palette ram's single port reads one entry a cycle
// during the scan, into a three-deep distance pipeline
// reset (aresetn low, synchronous) empties the queue and the result register;
// the palette holds whatever it held, entries must be written before queries
// a two-beat queue lets beats arrive during a scan; the result register lets
// the next command start while a result waits on m_tready
module fog_palette_nearest_color #(
    parameter int PALETTE_ENTRIES = fpnc_pkg::PALETTE_ENTRIES_DEF,
    parameter int FOG_LEVELS      = fpnc_pkg::FOG_LEVELS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_index, red_in, green_in, blue_in, fog_level
    input  logic [fpnc_pkg::S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [fpnc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // best_index, best_distance, source_index, level_echo
    output logic [fpnc_pkg::M_TDATA_W-1:0] m_tdata
);
    import fpnc_pkg::*;

    localparam int RES_W = $bits(fpnc_result_t);

    logic         q_valid;
    logic         q_pop;
    fpnc_item_t   q_item;
    fpnc_result_t m_result;

    // front end: decodes each beat and parks it in the queue
    fpnc_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .FOG_LEVELS      (FOG_LEVELS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back end: owns the palette ram, blends and scans
    fpnc_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .FOG_LEVELS      (FOG_LEVELS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    // struct lays best_index in the low bits, level_echo highest
    assign m_tdata = {{(M_TDATA_W - RES_W){1'b0}}, m_result};

endmodule

// File: rtl/core/fpnc_ram.sv
// generic single-port ram with registered read
module fpnc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/fpnc_front.sv
// input side: beat decode, command classification and a two-entry queue
module fpnc_front #(
    parameter int PALETTE_ENTRIES = fpnc_pkg::PALETTE_ENTRIES_DEF,
    parameter int FOG_LEVELS      = fpnc_pkg::FOG_LEVELS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fpnc_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [fpnc_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                q_valid,
    output fpnc_pkg::fpnc_item_t                q_item,
    input  logic                                q_pop
);
    import fpnc_pkg::*;

    localparam int QD   = 2;
    localparam int QAW  = $clog2(QD);
    localparam int QCW  = $clog2(QD + 1);
    localparam logic [IDX_W:0]   ENTRIES_LIM = (IDX_W + 1)'(PALETTE_ENTRIES);
    localparam logic [SAT_W-1:0] LVL_MAX     = SAT_W'(FOG_LEVELS - 1);
    localparam logic [QCW-1:0]   QD_CNT      = QCW'(QD);

    fpnc_item_t       item_reg [QD];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg,  count_next;
    fpnc_item_t       item_in;
    logic             push;
    logic [SAT_W-1:0] level_wide;

    // classify the beat: kind, index range and saturated fog level
    always_comb begin
        level_wide        = {1'b0, s_tdata[38:32]};
        item_in.kind      = cmd_kind_t'(s_tuser[0]);
        item_in.index     = s_tdata[7:0];
        item_in.in_range  = ({1'b0, s_tdata[7:0]} < ENTRIES_LIM);
        item_in.rgb       = s_tdata[31:8];
        item_in.level_raw = s_tdata[38:32];
        item_in.level_sat = (level_wide > LVL_MAX) ? LVL_MAX : level_wide;
    end

    assign s_tready = (count_reg != QD_CNT);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = item_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            item_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// File: rtl/core/fpnc_back.sv
// execution side: palette writes, fog blend, nearest-entry scan, result register
module fpnc_back #(
    parameter int PALETTE_ENTRIES = fpnc_pkg::PALETTE_ENTRIES_DEF,
    parameter int FOG_LEVELS      = fpnc_pkg::FOG_LEVELS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  fpnc_pkg::fpnc_item_t   q_item,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output fpnc_pkg::fpnc_result_t m_result
);
    import fpnc_pkg::*;

    localparam int AW       = $clog2(PALETTE_ENTRIES);
    localparam int SCALE_SH = 24;
    localparam int RECIP_W  = SCALE_SH + 1;
    localparam int PROD_W   = 2 * CH_W;
    localparam int SQ_W     = 2 * CH_W;
    localparam int unsigned DEN = FOG_LEVELS - 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** SCALE_SH) + DEN - 1) / DEN);
    localparam logic [AW-1:0] SCAN_LAST = AW'(PALETTE_ENTRIES - 1);
    localparam logic [1:0]    CH_LAST   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRC,
        ST_PROD,
        ST_SCALE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t               state_reg,    state_next;
    logic [IDX_W-1:0]     src_idx_reg,  src_idx_next;
    logic [LVL_W-1:0]     lvl_raw_reg,  lvl_raw_next;
    logic [SAT_W-1:0]     lvl_sat_reg,  lvl_sat_next;
    logic                 src_ok_reg,   src_ok_next;
    logic [2:0][CH_W-1:0] shade_reg,    shade_next;
    logic [1:0]           ch_reg,       ch_next;
    logic [PROD_W-1:0]    prod_reg,     prod_next;
    logic [AW-1:0]        scan_reg,     scan_next;
    logic                 rd_v_reg,     rd_v_next;
    logic [AW-1:0]        rd_tag_reg,   rd_tag_next;
    logic                 sq_v_reg,     sq_v_next;
    logic [AW-1:0]        sq_tag_reg,   sq_tag_next;
    logic [2:0][SQ_W-1:0] sq_reg,       sq_next;
    logic                 best_set_reg, best_set_next;
    logic [DIST_W-1:0]    best_dist_reg, best_dist_next;
    logic [AW-1:0]        best_idx_reg, best_idx_next;
    logic                 m_valid_reg,  m_valid_next;
    fpnc_result_t         res_reg,      res_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [RGB_W-1:0]     ram_rdata;
    logic [2:0][CH_W-1:0] pal_rgb;
    logic [PROD_W+RECIP_W-1:0] scaled;
    logic [CH_W-1:0]      quot;
    logic [CH_W-1:0]      blended;
    logic [CH_W-1:0]      diff;
    logic [DIST_W-1:0]    dist_sum;
    logic                 load_out;

    fpnc_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (q_item.rgb),
        .rdata (ram_rdata)
    );

    assign pal_rgb  = ram_rdata;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign ram_we   = q_pop && (q_item.kind == CMD_WRITE) && q_item.in_range;
    assign ram_addr = (state_reg == ST_SCAN) ? scan_reg : q_item.index[AW-1:0];
    assign load_out = (state_reg == ST_DRAIN) && !rd_v_reg && !sq_v_reg &&
                      (!m_valid_reg || m_tready);

    // truncated division by the fog step count as a reciprocal multiply
    assign scaled   = {{RECIP_W{1'b0}}, prod_reg} * {{PROD_W{1'b0}}, RECIP};
    assign quot     = scaled[SCALE_SH +: CH_W];
    assign blended  = shade_reg[0] + quot;
    assign dist_sum = DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);

    always_comb begin
        state_next     = state_reg;
        src_idx_next   = src_idx_reg;
        lvl_raw_next   = lvl_raw_reg;
        lvl_sat_next   = lvl_sat_reg;
        src_ok_next    = src_ok_reg;
        shade_next     = shade_reg;
        ch_next        = ch_reg;
        prod_next      = prod_reg;
        scan_next      = scan_reg;
        rd_v_next      = 1'b0;
        rd_tag_next    = rd_tag_reg;
        best_set_next  = best_set_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop && (q_item.kind == CMD_QUERY)) begin
                    src_idx_next = q_item.index;
                    lvl_raw_next = q_item.level_raw;
                    lvl_sat_next = q_item.level_sat;
                    src_ok_next  = q_item.in_range;
                    state_next   = ST_SRC;
                end
            end
            ST_SRC: begin
                shade_next    = src_ok_reg ? pal_rgb : '0;
                ch_next       = '0;
                best_set_next = 1'b0;
                state_next    = ST_PROD;
            end
            ST_PROD: begin
                prod_next  = {{CH_W{1'b0}}, CH_MAX - shade_reg[0]} *
                             {{(PROD_W-SAT_W){1'b0}}, lvl_sat_reg};
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                // rotate so the next channel sits in slot zero
                shade_next = {blended, shade_reg[2], shade_reg[1]};
                if (ch_reg == CH_LAST) begin
                    scan_next  = '0;
                    state_next = ST_SCAN;
                end else begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_PROD;
                end
            end
            ST_SCAN: begin
                rd_v_next   = 1'b1;
                rd_tag_next = scan_reg;
                if (scan_reg == SCAN_LAST) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (load_out) begin
                    res_next.best_index    = IDX_W'(best_idx_reg);
                    res_next.best_distance = best_dist_reg;
                    res_next.source_index  = src_idx_reg;
                    res_next.level_echo    = lvl_raw_reg;
                    m_valid_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // distance pipeline: squares, then sum and compare
        sq_v_next   = rd_v_reg;
        sq_tag_next = rd_tag_reg;
        for (int k = 0; k < 3; k++) begin
            diff = (shade_reg[k] > pal_rgb[k]) ? shade_reg[k] - pal_rgb[k]
                                               : pal_rgb[k] - shade_reg[k];
            sq_next[k] = {{CH_W{1'b0}}, diff} * {{CH_W{1'b0}}, diff};
        end
        if (sq_v_reg && (!best_set_reg || (dist_sum < best_dist_reg))) begin
            best_set_next  = 1'b1;
            best_dist_next = dist_sum;
            best_idx_next  = sq_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_v_reg     <= 1'b0;
            sq_v_reg     <= 1'b0;
            best_set_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_v_reg     <= rd_v_next;
            sq_v_reg     <= sq_v_next;
            best_set_reg <= best_set_next;
            m_valid_reg  <= m_valid_next;
        end
        src_idx_reg   <= src_idx_next;
        lvl_raw_reg   <= lvl_raw_next;
        lvl_sat_reg   <= lvl_sat_next;
        src_ok_reg    <= src_ok_next;
        shade_reg     <= shade_next;
        ch_reg        <= ch_next;
        prod_reg      <= prod_next;
        scan_reg      <= scan_next;
        rd_tag_reg    <= rd_tag_next;
        sq_tag_reg    <= sq_tag_next;
        sq_reg        <= sq_next;
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        res_reg       <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_result = res_reg;

    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_write_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("palette written during a query");

    a_pipe_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_v_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("distance stage busy outside a scan");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("result load lost");

    a_best_before_load: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> best_set_reg)
        else $error("result loaded without a scanned entry");

endmodule
